// ===== hw/rtl/arp_cache_lookup_replace_top_defines.svh =====
// Assertion macros shared by the address-resolution cache RTL.
`ifndef ARP_CACHE_LOOKUP_REPLACE_TOP_DEFINES_SVH
`define ARP_CACHE_LOOKUP_REPLACE_TOP_DEFINES_SVH

// Condition a implies condition b in the same cycle.
`define ARPC_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("arpc same-cycle check failed");

// Condition a implies condition b in the following cycle.
`define ARPC_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("arpc next-cycle check failed");

`endif

// ===== hw/rtl/arpc_pkg.sv =====
// Types and constants shared by the address-resolution cache modules.
package arpc_pkg;

  localparam int ARPC_TABLE_ENTRIES_DEF = 16;
  localparam int DEV_W  = 4;
  localparam int IP_W   = 32;
  localparam int MAC_W  = 48;
  localparam int TIME_W = 32;
  localparam int OSLOT_W = 4;

  typedef enum logic [2:0] {
    OUT_HIT      = 3'd0,
    OUT_MISS     = 3'd1,
    OUT_UPDATED  = 3'd2,
    OUT_FILLED   = 3'd3,
    OUT_REPLACED = 3'd4
  } outcome_t;

  typedef enum logic {
    ST_IDLE,
    ST_SWEEP
  } st_t;

  // Key broadcast to every cell during a sweep.
  typedef struct packed {
    logic [DEV_W-1:0] device;
    logic [IP_W-1:0]  ip;
  } query_t;

  // Running search state handed from cell to cell.
  typedef struct packed {
    logic              match_found;
    logic [MAC_W-1:0]  match_mac;
    logic              free_found;
    logic [MAC_W-1:0]  free_mac;
    logic [TIME_W-1:0] oldest_time;
    logic [MAC_W-1:0]  oldest_mac;
  } acc_t;

  // Write command broadcast to the cells; the slot travels beside it.
  typedef struct packed {
    logic              en;
    logic              set_tag;
    logic [DEV_W-1:0]  device;
    logic [IP_W-1:0]   ip;
    logic [TIME_W-1:0] stamp;
    logic              mac_en;
    logic [MAC_W-1:0]  mac;
  } wr_t;

endpackage

// ===== hw/rtl/arpc_cell.sv =====
// One table slot: holds an entry and folds it into the search state passed down the row.
module arpc_cell import arpc_pkg::*; #(
  parameter int IDX    = 0,
  parameter int SLOT_W = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  query_t            query,
  input  wr_t               wr,
  input  logic [SLOT_W-1:0] wr_slot,
  input  acc_t              acc_in,
  input  logic [SLOT_W-1:0] match_slot_in,
  input  logic [SLOT_W-1:0] free_slot_in,
  input  logic [SLOT_W-1:0] oldest_slot_in,
  output acc_t              acc_out,
  output logic [SLOT_W-1:0] match_slot_out,
  output logic [SLOT_W-1:0] free_slot_out,
  output logic [SLOT_W-1:0] oldest_slot_out
);

  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

  logic              valid;
  logic [DEV_W-1:0]  device;
  logic [IP_W-1:0]   ip;
  logic [MAC_W-1:0]  mac;
  logic [TIME_W-1:0] last_use;

  logic              hit_here;
  logic              take_free;
  logic              take_oldest;
  logic              wr_here;
  acc_t              acc_next;
  logic [SLOT_W-1:0] match_slot_next;
  logic [SLOT_W-1:0] free_slot_next;
  logic [SLOT_W-1:0] oldest_slot_next;

  assign wr_here = wr.en && (wr_slot == MY_SLOT);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr_here && wr.set_tag) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_here) begin
      last_use <= wr.stamp;
      if (wr.set_tag) begin
        device <= wr.device;
        ip     <= wr.ip;
      end
      if (wr.mac_en) begin
        mac <= wr.mac;
      end
    end
  end

  // Earlier slots win matches and free slots; the first cell always seeds the oldest.
  always_comb begin
    hit_here    = valid && (device == query.device) && (ip == query.ip);
    take_free   = !valid && !acc_in.free_found;
    take_oldest = (IDX == 0) || (last_use < acc_in.oldest_time);

    acc_next         = acc_in;
    match_slot_next  = match_slot_in;
    free_slot_next   = free_slot_in;
    oldest_slot_next = oldest_slot_in;

    if (hit_here && !acc_in.match_found) begin
      acc_next.match_found = 1'b1;
      acc_next.match_mac   = mac;
      match_slot_next      = MY_SLOT;
    end
    if (take_free) begin
      acc_next.free_found = 1'b1;
      acc_next.free_mac   = mac;
      free_slot_next      = MY_SLOT;
    end
    if (take_oldest) begin
      acc_next.oldest_time = last_use;
      acc_next.oldest_mac  = mac;
      oldest_slot_next     = MY_SLOT;
    end
  end

  always_ff @(posedge clk) begin
    acc_out         <= acc_next;
    match_slot_out  <= match_slot_next;
    free_slot_out   <= free_slot_next;
    oldest_slot_out <= oldest_slot_next;
  end

endmodule

// ===== hw/rtl/arp_cache_lookup_replace_top.sv =====
// Top level of the address-resolution cache: request control, cell row and result register.
//
// Channel   Dir  Fields
// s_axis    in   tuser: action; tdata: device, ip_addr, mac_value, mac_present, now
// m_axis    out  tuser: outcome; tdata: slot, mac_out
//
// After a request transfer the search state walks the row of cells one slot per cycle,
// then a decision step loads the result register and, for a write action, the table.
// One request sweeps at a time; the next is taken in the cycle after the decision,
// even while the last result waits.
// rst clears all valid marks and the control state; no clearing pass is needed.
// A stalled result holds the decision cycle, so the table is not written early.
`include "arp_cache_lookup_replace_top_defines.svh"

module arp_cache_lookup_replace_top import arpc_pkg::*; #(
  parameter int TABLE_ENTRIES = ARPC_TABLE_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [0:0]   s_axis_tuser,   // [0] action
  // [3:0] device, [35:4] ip_addr, [83:36] mac_value, [84] mac_present,
  // [116:85] now, [119:117] zero
  input  logic [119:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [2:0]   m_axis_tuser,   // [2:0] outcome
  output logic [55:0]  m_axis_tdata    // [3:0] slot, [51:4] mac_out, [55:52] zero
);

  localparam int SLOT_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES);

  st_t               state;
  st_t               state_next;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic              decide;

  logic              q_action;
  query_t            query;
  logic [MAC_W-1:0]  q_mac;
  logic              q_mac_present;
  logic [TIME_W-1:0] q_now;

  logic              out_valid;
  outcome_t          out_outcome;
  logic [OSLOT_W-1:0] out_slot;
  logic [MAC_W-1:0]  out_mac;
  logic              out_miss;

  outcome_t          res_outcome;
  logic [SLOT_W-1:0] res_slot;
  logic [MAC_W-1:0]  res_mac;
  wr_t               wr;

  acc_t              chain_acc    [TABLE_ENTRIES+1];
  logic [SLOT_W-1:0] chain_match  [TABLE_ENTRIES+1];
  logic [SLOT_W-1:0] chain_free   [TABLE_ENTRIES+1];
  logic [SLOT_W-1:0] chain_oldest [TABLE_ENTRIES+1];

  logic              s_xfer;

  assign s_xfer = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (s_xfer) state_next = ST_SWEEP;
      ST_SWEEP: if (decide) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    decide        = 1'b0;
    cnt_next      = cnt;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cnt_next      = '0;
      end
      ST_SWEEP: begin
        if (cnt == CNT_LAST) begin
          decide = !out_valid || m_axis_tready;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      default: cnt_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (decide) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      q_action      <= s_axis_tuser[0];
      query.device  <= s_axis_tdata[3:0];
      query.ip      <= s_axis_tdata[35:4];
      q_mac         <= s_axis_tdata[83:36];
      q_mac_present <= s_axis_tdata[84];
      q_now         <= s_axis_tdata[116:85];
    end
    if (decide) begin
      out_outcome <= res_outcome;
      out_slot    <= OSLOT_W'(res_slot);
      out_mac     <= res_mac;
    end
  end

  // Seed of the row; the first cell overwrites the oldest fields unconditionally.
  assign chain_acc[0]    = '0;
  assign chain_match[0]  = '0;
  assign chain_free[0]   = '0;
  assign chain_oldest[0] = '0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    arpc_cell #(
      .IDX    (i),
      .SLOT_W (SLOT_W)
    ) u_cell (
      .clk             (clk),
      .rst             (rst),
      .query           (query),
      .wr              (wr),
      .wr_slot         (res_slot),
      .acc_in          (chain_acc[i]),
      .match_slot_in   (chain_match[i]),
      .free_slot_in    (chain_free[i]),
      .oldest_slot_in  (chain_oldest[i]),
      .acc_out         (chain_acc[i+1]),
      .match_slot_out  (chain_match[i+1]),
      .free_slot_out   (chain_free[i+1]),
      .oldest_slot_out (chain_oldest[i+1])
    );
  end

  // Decision on the search state leaving the last cell.
  always_comb begin
    acc_t fin;
    fin         = chain_acc[TABLE_ENTRIES];
    res_outcome = OUT_MISS;
    res_slot    = '0;
    res_mac     = '0;
    wr          = '0;
    wr.device   = query.device;
    wr.ip       = query.ip;
    wr.stamp    = q_now;
    wr.mac_en   = q_mac_present;
    wr.mac      = q_mac;
    if (!q_action) begin
      if (fin.match_found) begin
        res_outcome = OUT_HIT;
        res_slot    = chain_match[TABLE_ENTRIES];
        res_mac     = fin.match_mac;
      end
    end else begin
      wr.en = decide;
      if (fin.match_found) begin
        res_outcome = OUT_UPDATED;
        res_slot    = chain_match[TABLE_ENTRIES];
        res_mac     = q_mac_present ? q_mac : fin.match_mac;
      end else if (fin.free_found) begin
        res_outcome = OUT_FILLED;
        res_slot    = chain_free[TABLE_ENTRIES];
        res_mac     = q_mac_present ? q_mac : fin.free_mac;
        wr.set_tag  = 1'b1;
      end else begin
        res_outcome = OUT_REPLACED;
        res_slot    = chain_oldest[TABLE_ENTRIES];
        res_mac     = q_mac_present ? q_mac : fin.oldest_mac;
        wr.set_tag  = 1'b1;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_outcome;
  assign m_axis_tdata  = {4'b0, out_mac, out_slot};

  assign out_miss = out_valid && (out_outcome == OUT_MISS);

  `ARPC_ASSERT_NEXT(a_accept_starts_sweep, clk, rst, s_xfer, state == ST_SWEEP)
  `ARPC_ASSERT_NEXT(a_decide_loads_result, clk, rst, decide, m_axis_tvalid)
  `ARPC_ASSERT_IMPLY(a_cnt_bounded, clk, rst, state == ST_SWEEP, cnt <= CNT_LAST)
  `ARPC_ASSERT_IMPLY(a_miss_is_zero, clk, rst, out_miss, (out_slot == '0) && (out_mac == '0))

endmodule
